// ===== rtl/bctc_pkg.sv =====
`timescale 1ns / 1ps
package bctc_pkg;
   localparam int ADDR_W = 48;
   localparam int SLOT_W = 7;
   localparam int STATUS_W = 4;
   localparam int MODE_W = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_GET = 2'd0,
      MODE_RELEASE = 2'd1,
      MODE_FLUSH = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   localparam logic [STATUS_W-1:0] ST_HIT = 4'd0;
   localparam logic [STATUS_W-1:0] ST_FILL = 4'd1;
   localparam logic [STATUS_W-1:0] ST_FILL_WB = 4'd2;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 4'd3;
   localparam logic [STATUS_W-1:0] ST_NO_VICTIM = 4'd4;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 4'd5;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 4'd6;
   localparam logic [STATUS_W-1:0] ST_FLUSH_ENTRY = 4'd7;
   localparam logic [STATUS_W-1:0] ST_FLUSH_DONE = 4'd8;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request fields
      logic search;    // register match/victim scan results
      logic read;      // addr memory read of the chosen slot
      logic commit;    // update table, drive result
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic search_done;
   } dp_status_type;
endpackage

// ===== rtl/bctc_datapath.sv =====
`timescale 1ns / 1ps
module bctc_datapath #(
   parameter int NUM_SLOTS = 128,
   parameter int BLOCK_BYTES = 512,
   parameter int REF_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bctc_pkg::dp_cmd_type         cmd,
   output bctc_pkg::dp_status_type      stat,
   input  logic [1:0]                   req_mode,
   input  logic [47:0]                  req_byte_addr,
   input  logic [6:0]                   req_slot_index,
   input  logic                         req_mark_dirty,
   output logic                         rsp_valid,
   output logic [3:0]                   rsp_status,
   output logic [6:0]                   rsp_slot,
   output logic [47:0]                  rsp_writeback_addr,
   output logic [47:0]                  rsp_fill_addr
);
   import bctc_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int OFF_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
   localparam bit BLK_POW2 = ((BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0);

   logic [ADDR_W-1:0] addr_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff, dirty_ff;
   logic [REF_BITS-1:0] refs_ff [NUM_SLOTS];

   logic [1:0] mode_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [SLOT_W-1:0] sidx_ff;
   logic mark_ff;
   logic misal_ff;

   // search vectors, one bit per slot, registered
   logic [NUM_SLOTS-1:0] hit_vec_in, hit_vec_ff;
   logic [NUM_SLOTS-1:0] free_in, clean_in, dirty0_in, dflush_in;
   logic [NUM_SLOTS-1:0] free_ff, clean_ff, dirty0_ff, dflush_ff;

   logic [IDX_W-1:0] pick_ff;
   logic pick_ok_ff, pick_hit_ff, pick_wb_ff;
   logic [ADDR_W-1:0] rd_addr_ff;

   logic rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ADDR_W-1:0] wb_ff, fill_ff, wb_in, fill_in;

   // misaligned check
   logic misal_in;
   always_comb begin
      if (BLOCK_BYTES == 1) misal_in = 1'b0;
      else if (BLK_POW2) misal_in = |req_byte_addr[OFF_W-1:0];
      else misal_in = (req_byte_addr % BLOCK_BYTES) != '0;
   end

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         hit_vec_in[i] = valid_ff[i] && (addr_mem[i] == addr_ff);
         free_in[i] = !valid_ff[i];
         clean_in[i] = (refs_ff[i] == '0) && !dirty_ff[i];
         dirty0_in[i] = (refs_ff[i] == '0);
         dflush_in[i] = valid_ff[i] && dirty_ff[i];
      end
   end

   function automatic logic [IDX_W:0] first_one(input logic [NUM_SLOTS-1:0] v);
      logic [IDX_W:0] r;
      r = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--)
         if (v[i]) r = {1'b1, IDX_W'(i)};
      return r;
   endfunction

   // pick stage, from registered vectors
   logic [IDX_W:0] f_hit, f_free, f_clean, f_d0, f_fl;
   logic [IDX_W-1:0] pick_in;
   logic pick_ok_in, pick_hit_in;
   always_comb begin
      f_hit = first_one(hit_vec_ff);
      f_free = first_one(free_ff);
      f_clean = first_one(clean_ff);
      f_d0 = first_one(dirty0_ff);
      f_fl = first_one(dflush_ff);
      pick_hit_in = 1'b0;
      pick_ok_in = 1'b0;
      pick_in = '0;
      case (mode_ff)
         MODE_GET: begin
            if (f_hit[IDX_W]) begin
               pick_hit_in = 1'b1; pick_ok_in = 1'b1; pick_in = f_hit[IDX_W-1:0];
            end else if (f_free[IDX_W]) begin
               pick_ok_in = 1'b1; pick_in = f_free[IDX_W-1:0];
            end else if (f_clean[IDX_W]) begin
               pick_ok_in = 1'b1; pick_in = f_clean[IDX_W-1:0];
            end else if (f_d0[IDX_W]) begin
               pick_ok_in = 1'b1; pick_in = f_d0[IDX_W-1:0];
            end
         end
         MODE_FLUSH: begin
            pick_ok_in = f_fl[IDX_W];
            pick_in = f_fl[IDX_W-1:0];
         end
         default: begin
            pick_ok_in = (int'(sidx_ff) < NUM_SLOTS);
            pick_in = IDX_W'(sidx_ff);
            if (pick_ok_in) pick_ok_in = valid_ff[IDX_W'(sidx_ff)];
         end
      endcase
   end

   // result fields of the committed request
   always_comb begin
      status_in = ST_IGNORED;
      slot_in = '0;
      wb_in = '0;
      fill_in = '0;
      case (mode_ff)
         MODE_GET: begin
            if (misal_ff) status_in = ST_MISALIGNED;
            else if (!pick_ok_ff) status_in = ST_NO_VICTIM;
            else if (pick_hit_ff) begin
               status_in = ST_HIT;
               slot_in = SLOT_W'(pick_ff);
            end else begin
               status_in = pick_wb_ff ? ST_FILL_WB : ST_FILL;
               slot_in = SLOT_W'(pick_ff);
               wb_in = pick_wb_ff ? rd_addr_ff : '0;
               fill_in = addr_ff;
            end
         end
         MODE_RELEASE: begin
            if (pick_ok_ff) begin
               status_in = ST_RELEASED;
               slot_in = SLOT_W'(pick_ff);
            end
         end
         MODE_FLUSH: begin
            if (pick_ok_ff) begin
               status_in = ST_FLUSH_ENTRY;
               slot_in = SLOT_W'(pick_ff);
               wb_in = rd_addr_ff;
            end else status_in = ST_FLUSH_DONE;
         end
         default: status_in = ST_IGNORED;
      endcase
   end

   assign stat.search_done = cmd.read;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         addr_ff <= req_byte_addr;
         sidx_ff <= req_slot_index;
         mark_ff <= req_mark_dirty;
         misal_ff <= misal_in;
      end
      if (cmd.search) begin
         hit_vec_ff <= hit_vec_in;
         free_ff <= free_in;
         clean_ff <= clean_in;
         dirty0_ff <= dirty0_in;
         dflush_ff <= dflush_in;
      end
      if (cmd.read) begin
         pick_ff <= pick_in;
         pick_ok_ff <= pick_ok_in;
         pick_hit_ff <= pick_hit_in;
         pick_wb_ff <= valid_ff[pick_in] && dirty_ff[pick_in];
         rd_addr_ff <= addr_mem[pick_in];
      end
      if (cmd.commit && mode_ff == MODE_GET && !misal_ff && pick_ok_ff && !pick_hit_ff)
         addr_mem[pick_ff] <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         dirty_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) refs_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit) begin
            status_ff <= status_in;
            slot_ff <= slot_in;
            wb_ff <= wb_in;
            fill_ff <= fill_in;
            case (mode_ff)
               MODE_GET: begin
                  if (!misal_ff && pick_ok_ff) begin
                     if (pick_hit_ff) begin
                        if (refs_ff[pick_ff] != REF_MAX)
                           refs_ff[pick_ff] <= refs_ff[pick_ff] + 1'b1;
                     end else begin
                        valid_ff[pick_ff] <= 1'b1;
                        dirty_ff[pick_ff] <= 1'b0;
                        refs_ff[pick_ff] <= REF_BITS'(1);
                     end
                  end
               end
               MODE_RELEASE: begin
                  if (pick_ok_ff) begin
                     if (mark_ff) dirty_ff[pick_ff] <= 1'b1;
                     if (refs_ff[pick_ff] != '0)
                        refs_ff[pick_ff] <= refs_ff[pick_ff] - 1'b1;
                  end
               end
               MODE_FLUSH: begin
                  if (pick_ok_ff) dirty_ff[pick_ff] <= 1'b0;
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_slot = slot_ff;
   assign rsp_writeback_addr = wb_ff;
   assign rsp_fill_addr = fill_ff;
endmodule

// ===== rtl/bctc_ctrl.sv =====
`timescale 1ns / 1ps
module bctc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output bctc_pkg::dp_cmd_type    cmd,
   input  bctc_pkg::dp_status_type stat
);
   import bctc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_READ, S_COMMIT} state_type;
   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (start) state_ff <= S_SEARCH;
            S_SEARCH: state_ff <= S_READ;
            S_READ: if (stat.search_done) state_ff <= S_COMMIT;
            S_COMMIT: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   always_comb begin
      cmd.capture = (state_ff == S_IDLE) && start;
      cmd.search = (state_ff == S_SEARCH);
      cmd.read = (state_ff == S_READ);
      cmd.commit = (state_ff == S_COMMIT);
   end
endmodule

// ===== rtl/block_cache_tag_controller.sv =====
`timescale 1ns / 1ps
// Tag controller of a fully associative write-back block cache. A request is
// taken when start is high and busy is low; exactly one result beat follows,
// rsp_valid high for one cycle, registered at the end of the commit step. Busy
// stays high until the table update is done, so a new request is taken only
// after the last one has passed the four controller steps: capture, parallel
// tag compare and victim scan, slot pick with address read, table update.
// The receiver cannot stall; no reset clearing pass is needed.
module block_cache_tag_controller #(
   parameter int NUM_SLOTS = 128,
   parameter int BLOCK_BYTES = 512,
   parameter int REF_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [47:0] req_byte_addr,
   input  logic [6:0]  req_slot_index,
   input  logic        req_mark_dirty,
   output logic        rsp_valid,
   output logic [3:0]  rsp_status,
   output logic [6:0]  rsp_slot,
   output logic [47:0] rsp_writeback_addr,
   output logic [47:0] rsp_fill_addr
);
   import bctc_pkg::*;

   dp_cmd_type cmd;
   dp_status_type stat;

   bctc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .cmd(cmd), .stat(stat)
   );

   bctc_datapath #(
      .NUM_SLOTS(NUM_SLOTS), .BLOCK_BYTES(BLOCK_BYTES), .REF_BITS(REF_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_mode(req_mode), .req_byte_addr(req_byte_addr),
      .req_slot_index(req_slot_index), .req_mark_dirty(req_mark_dirty),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_slot(rsp_slot),
      .rsp_writeback_addr(rsp_writeback_addr), .rsp_fill_addr(rsp_fill_addr)
   );
endmodule

// ===== rtl/bctc_checker.sv =====
`timescale 1ns / 1ps
module bctc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [3:0]  rsp_status,
   input logic [47:0] rsp_fill_addr
);
   import bctc_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised");
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid) else $error("result beat missing");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FLUSH_DONE) else $error("bad status");
   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_FILL && rsp_status != ST_FILL_WB)
      |-> rsp_fill_addr == '0) else $error("fill addr set");
endmodule

bind block_cache_tag_controller bctc_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_fill_addr(rsp_fill_addr)
);
